[src/toroidal_life_grid_stepper_defines.svh]
// ----------------------------------------------------------------------------
// toroidal_life_grid_stepper_defines
// Assertion macros shared by the grid stepper RTL.
// ----------------------------------------------------------------------------
`ifndef TOROIDAL_LIFE_GRID_STEPPER_DEFINES_SVH
`define TOROIDAL_LIFE_GRID_STEPPER_DEFINES_SVH

// same-cycle implication, clocked on clk, off during rst
`define TLG_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during rst
`define TLG_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/tlg_pkg.sv]
// ----------------------------------------------------------------------------
// tlg_pkg
// Grid geometry, rule counts and operation codes for the grid stepper.
// ----------------------------------------------------------------------------
package tlg_pkg;

  localparam int GRID_HALF = 32;
  localparam int GRID_SIDE = 2 * GRID_HALF;
  localparam int ROW_W     = $clog2(GRID_SIDE);

  // neighborhood count of the 3x3 block, cell included
  localparam int COUNT_W          = 4;
  localparam logic [COUNT_W-1:0] BORN_COUNT = COUNT_W'(3);
  localparam logic [COUNT_W-1:0] KEEP_COUNT = COUNT_W'(4);

  // step sequence: one read for the wrap row above, then every row, then a
  // final beat that uses the saved first row as the row below the last
  localparam int STEP_LAST_SEQ = GRID_SIDE + 2;
  localparam int SEQ_W         = $clog2(STEP_LAST_SEQ + 1);

  typedef logic [GRID_SIDE-1:0] row_t;
  typedef logic [ROW_W-1:0]     idx_t;

  typedef enum logic [1:0] {
    OP_TOGGLE = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_STEP   = 2'd2,
    OP_READ   = 2'd3
  } op_t;

endpackage

[src/tlg_ifs.sv]
// ----------------------------------------------------------------------------
// tlg_ifs
// Valid/ready channels for operation items and cell results.
// ----------------------------------------------------------------------------
interface tlg_item_if;
  import tlg_pkg::*;

  logic valid;
  logic ready;
  op_t  op;
  idx_t col;
  idx_t row;

  modport source (output valid, output op, output col, output row, input ready);
  modport sink   (input valid, input op, input col, input row, output ready);
endinterface

interface tlg_result_if;
  import tlg_pkg::*;

  logic valid;
  logic ready;
  logic cell_alive;
  op_t  op_echo;

  modport source (output valid, output cell_alive, output op_echo, input ready);
  modport sink   (input valid, input cell_alive, input op_echo, output ready);
endinterface

[src/toroidal_life_grid_stepper.sv]
// ----------------------------------------------------------------------------
// toroidal_life_grid_stepper
// Game of Life (B3/S23) on a 64x64 torus, one row per memory word.
//
//   channel  dir  payload               purpose
//   item     in   op, col, row          toggle / clear / step / read
//   result   out  cell_alive, op_echo   addressed cell after the operation
//
// Toggle, clear and read: the item beat moves the block to its update state,
//   which registers the result; no new item is taken before that.
// Step: walks the row memory (wrap row, 64 rows, wrap beat),
//   one row read and one row written per cycle, then fetches the cell.
// Reset clears all per-row valid bits together; clear does the same. No sweep.
// A stalled result holds the block in its update cycle; the next item is
//   taken as soon as the result register has been loaded.
// ----------------------------------------------------------------------------
`include "toroidal_life_grid_stepper_defines.svh"

module toroidal_life_grid_stepper (
  input logic          clk,
  input logic          rst,
  tlg_item_if.sink     item,
  tlg_result_if.source result
);
  import tlg_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_STEP,
    S_FETCH,
    S_UPDATE
  } state_t;

  state_t                 state;
  logic [SEQ_W-1:0]       seq;
  op_t                    op_q;
  idx_t                   col_q;
  idx_t                   row_q;
  idx_t                   rd_row;
  logic [GRID_SIDE-1:0]   valid_rows;
  row_t                   above;
  row_t                   cur;
  row_t                   first;
  logic                   out_valid;
  logic                   out_alive;
  op_t                    out_op;

  logic                   accept;
  logic                   out_free;
  logic                   rd_en;
  idx_t                   rd_addr;
  row_t                   rd_data;
  row_t                   data_m;
  logic                   wr_en;
  idx_t                   wr_addr;
  row_t                   wr_data;
  row_t                   below;
  row_t                   rule_row;
  logic                   step_wr;
  logic                   step_last;
  logic                   cell_bit;

  assign item.ready        = (state == S_IDLE);
  assign accept            = item.valid && item.ready;
  assign out_free          = !out_valid || result.ready;
  assign result.valid      = out_valid;
  assign result.cell_alive = out_alive;
  assign result.op_echo    = out_op;

  // rows never written since reset or clear read as empty
  assign data_m    = rd_data & {GRID_SIDE{valid_rows[rd_row]}};
  assign cell_bit  = data_m[col_q];
  assign step_last = (seq == SEQ_W'(STEP_LAST_SEQ));
  assign step_wr   = (state == S_STEP) && (seq >= SEQ_W'(3));
  assign below     = step_last ? first : data_m;

  tlg_row_rule u_rule (
    .above    (above),
    .cur      (cur),
    .below    (below),
    .next_row (rule_row)
  );

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = item.row;
    wr_en   = 1'b0;
    wr_addr = row_q;
    wr_data = rule_row;
    case (state)
      S_IDLE: begin
        rd_en   = accept;
        // a step starts with the wrap row above row 0
        rd_addr = (item.op == OP_STEP) ? idx_t'(GRID_SIDE - 1) : item.row;
      end
      S_STEP: begin
        rd_en   = (seq <= SEQ_W'(GRID_SIDE));
        rd_addr = ROW_W'(seq - SEQ_W'(1));
        wr_en   = step_wr;
        wr_addr = ROW_W'(seq - SEQ_W'(3));
        wr_data = rule_row;
      end
      S_FETCH: begin
        rd_en   = 1'b1;
        rd_addr = row_q;
      end
      S_UPDATE: begin
        wr_en   = out_free && (op_q == OP_TOGGLE);
        wr_addr = row_q;
        wr_data = data_m ^ (row_t'(1) << col_q);
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  tlg_ram #(
    .WIDTH (GRID_SIDE),
    .DEPTH (GRID_SIDE)
  ) u_rows (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      seq        <= '0;
      valid_rows <= '0;
      out_valid  <= 1'b0;
    end else begin
      // drained beat, unless a new one is loaded in the same cycle
      if (result.ready && !((state == S_UPDATE) && out_free)) begin
        out_valid <= 1'b0;
      end
      if (rd_en) begin
        rd_row <= rd_addr;
      end
      if (wr_en) begin
        valid_rows[wr_addr] <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            op_q  <= item.op;
            col_q <= item.col;
            row_q <= item.row;
            seq   <= SEQ_W'(1);
            if (item.op == OP_CLEAR) begin
              valid_rows <= '0;
            end
            state <= (item.op == OP_STEP) ? S_STEP : S_UPDATE;
          end
        end
        S_STEP: begin
          seq <= seq + SEQ_W'(1);
          if (seq == SEQ_W'(1)) begin
            above <= data_m;
          end else if (seq == SEQ_W'(2)) begin
            cur   <= data_m;
            first <= data_m;
          end else begin
            above <= cur;
            cur   <= data_m;
          end
          if (step_last) begin
            state <= S_FETCH;
          end
        end
        S_FETCH: begin
          state <= S_UPDATE;
        end
        S_UPDATE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_op    <= op_q;
            out_alive <= (op_q == OP_TOGGLE) ? !cell_bit : cell_bit;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `TLG_ASSERT_NXT(a_step_enters, accept && (item.op == OP_STEP), (state == S_STEP) && (seq == SEQ_W'(1)), "step did not start its row walk")
  `TLG_ASSERT_NXT(a_clear_empties, accept && (item.op == OP_CLEAR), valid_rows == '0, "clear left rows valid")
  `TLG_ASSERT_NXT(a_step_fills, (state == S_STEP) && step_last, (&valid_rows) && (state == S_FETCH), "step did not rewrite every row")
  `TLG_ASSERT_IMP(a_no_rw_clash, wr_en && rd_en, wr_addr != rd_addr, "row read and written in the same cycle")

endmodule

[src/tlg_ram.sv]
// ----------------------------------------------------------------------------
// tlg_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module tlg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[src/tlg_row_rule.sv]
// ----------------------------------------------------------------------------
// tlg_row_rule
// Next generation of one row from the old rows above, current and below.
// ----------------------------------------------------------------------------
module tlg_row_rule (
  input  tlg_pkg::row_t above,
  input  tlg_pkg::row_t cur,
  input  tlg_pkg::row_t below,
  output tlg_pkg::row_t next_row
);
  import tlg_pkg::*;

  always_comb begin
    int                 l;
    int                 r;
    logic [COUNT_W-1:0] cnt;
    next_row = '0;
    for (int c = 0; c < GRID_SIDE; c++) begin
      // columns wrap around the torus
      l   = (c == 0) ? GRID_SIDE - 1 : c - 1;
      r   = (c == GRID_SIDE - 1) ? 0 : c + 1;
      cnt = COUNT_W'(above[l]) + COUNT_W'(above[c]) + COUNT_W'(above[r])
          + COUNT_W'(cur[l])   + COUNT_W'(cur[c])   + COUNT_W'(cur[r])
          + COUNT_W'(below[l]) + COUNT_W'(below[c]) + COUNT_W'(below[r]);
      next_row[c] = (cnt == BORN_COUNT) || ((cnt == KEEP_COUNT) && cur[c]);
    end
  end

endmodule

[tb/toroidal_life_grid_stepper_test.sv]
// ----------------------------------------------------------------------------
// toroidal_life_grid_stepper_test
// Drives toggle, clear, step and read beats into the 64x64 life grid and
// checks every result beat against a torus bitmap model or its typed value. A
// short table of directed beats covers reset state, corner cells and wrapped
// patterns. Random episodes follow: each seeds a small window, steps it a few
// times and reads near it. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module toroidal_life_grid_stepper_test;
  import tlg_pkg::*;

  localparam int ITEM_TARGET   = 1750;
  localparam int IDLE_LIMIT    = 5000;
  localparam int DRAIN_CYCLES  = 80;

  typedef struct {
    op_t  op;
    idx_t col;
    idx_t row;
    bit   typed;
    logic alive;
  } plan_row_t;

  typedef struct {
    logic alive;
    op_t  op;
  } cell_result_t;

  logic clk;
  logic rst;

  tlg_item_if   item_ch ();
  tlg_result_if result_ch ();

  toroidal_life_grid_stepper dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  row_t         board [GRID_SIDE];
  cell_result_t pending_cells [$];
  plan_row_t    plan [$];

  bit   cur_typed;
  logic cur_typed_alive;
  bit   quiet;
  int   stall_left;
  int   idle_cycles;
  int   errors;
  int   items_sent;
  int   results_checked;
  int   op_counts [4];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // gap length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // one generation over the whole torus, from a copy of the old board
  function automatic void advance_generation();
    row_t prev [GRID_SIDE];
    logic [COUNT_W-1:0] cnt;
    idx_t ru, rd, cl, cr, ri, ci;
    for (int r = 0; r < GRID_SIDE; r++) prev[r] = board[r];
    for (int r = 0; r < GRID_SIDE; r++) begin
      ri = idx_t'(r);
      ru = ri - 1'b1;
      rd = ri + 1'b1;
      for (int c = 0; c < GRID_SIDE; c++) begin
        ci = idx_t'(c);
        cl = ci - 1'b1;
        cr = ci + 1'b1;
        cnt = COUNT_W'(prev[ru][cl]) + COUNT_W'(prev[ru][ci]) + COUNT_W'(prev[ru][cr])
            + COUNT_W'(prev[ri][cl]) + COUNT_W'(prev[ri][ci]) + COUNT_W'(prev[ri][cr])
            + COUNT_W'(prev[rd][cl]) + COUNT_W'(prev[rd][ci]) + COUNT_W'(prev[rd][cr]);
        if (cnt == BORN_COUNT) board[r][c] = 1'b1;
        else if (cnt == KEEP_COUNT) board[r][c] = prev[r][c];
        else board[r][c] = 1'b0;
      end
    end
  endfunction

  task automatic drive_item(op_t op, idx_t col, idx_t row, bit typed, logic alive);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cur_typed       = typed;
    cur_typed_alive = alive;
    item_ch.op    <= op;
    item_ch.col   <= col;
    item_ch.row   <= row;
    item_ch.valid <= 1'b1;
    do @(posedge clk); while (!item_ch.ready);
    @(negedge clk);
    items_sent++;
  endtask

  // result side stalls
  always @(negedge clk) begin
    if (stall_left > 0) begin
      result_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      result_ch.ready <= 1'b1;
      if (!quiet && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  // model update on item beats, compare on result beats
  always @(posedge clk) begin
    cell_result_t want;
    cell_result_t got;
    if (!rst) begin
      if (result_ch.valid && result_ch.ready) begin
        results_checked++;
        if (pending_cells.size() == 0) begin
          $error("result beat with no pending expectation: cell_alive %0b op_echo %0d",
                 result_ch.cell_alive, result_ch.op_echo);
          errors++;
        end else begin
          want = pending_cells.pop_front();
          if (result_ch.cell_alive !== want.alive) begin
            $error("cell_alive: expected %0b, actual %0b", want.alive, result_ch.cell_alive);
            errors++;
          end
          if (result_ch.op_echo !== want.op) begin
            $error("op_echo: expected %0d, actual %0d", want.op, result_ch.op_echo);
            errors++;
          end
        end
      end
      if (item_ch.valid && item_ch.ready) begin
        op_counts[item_ch.op]++;
        case (item_ch.op)
          OP_TOGGLE: board[item_ch.row][item_ch.col] = ~board[item_ch.row][item_ch.col];
          OP_CLEAR: begin
            for (int r = 0; r < GRID_SIDE; r++) board[r] = '0;
          end
          OP_STEP: advance_generation();
          default: ;
        endcase
        got.alive = cur_typed ? cur_typed_alive : board[item_ch.row][item_ch.col];
        got.op    = item_ch.op;
        pending_cells.push_back(got);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no beat for %0d cycles, %0d results pending",
                 IDLE_LIMIT, pending_cells.size());
        $display("FAIL toroidal_life_grid_stepper");
        $finish;
      end
    end
  end

  initial begin
    int   n_seed;
    int   n_steps;
    int   n_reads;
    idx_t ox;
    idx_t oy;
    clk             = 1'b0;
    rst             = 1'b1;
    quiet           = 1'b0;
    stall_left      = 0;
    idle_cycles     = 0;
    errors          = 0;
    items_sent      = 0;
    results_checked = 0;
    cur_typed       = 1'b0;
    cur_typed_alive = 1'b0;
    for (int i = 0; i < 4; i++) op_counts[i] = 0;
    for (int r = 0; r < GRID_SIDE; r++) board[r] = '0;
    item_ch.valid   = 1'b0;
    item_ch.op      = OP_READ;
    item_ch.col     = '0;
    item_ch.row     = '0;
    result_ch.ready = 1'b0;

    // empty board after reset, corner cells
    plan.push_back('{OP_READ,   6'd0,  6'd0,  1'b1, 1'b0});
    plan.push_back('{OP_READ,   6'd63, 6'd63, 1'b1, 1'b0});
    plan.push_back('{OP_TOGGLE, 6'd0,  6'd0,  1'b1, 1'b1});
    plan.push_back('{OP_TOGGLE, 6'd63, 6'd63, 1'b1, 1'b1});
    plan.push_back('{OP_READ,   6'd63, 6'd63, 1'b1, 1'b1});
    plan.push_back('{OP_TOGGLE, 6'd0,  6'd0,  1'b1, 1'b0});
    // clear still reports the addressed cell
    plan.push_back('{OP_CLEAR,  6'd63, 6'd63, 1'b1, 1'b0});
    plan.push_back('{OP_READ,   6'd63, 6'd63, 1'b1, 1'b0});
    plan.push_back('{OP_STEP,   6'd0,  6'd0,  1'b1, 1'b0});
    // blinker split across the column wrap
    plan.push_back('{OP_TOGGLE, 6'd63, 6'd0,  1'b1, 1'b1});
    plan.push_back('{OP_TOGGLE, 6'd0,  6'd0,  1'b1, 1'b1});
    plan.push_back('{OP_TOGGLE, 6'd1,  6'd0,  1'b1, 1'b1});
    plan.push_back('{OP_STEP,   6'd0,  6'd63, 1'b0, 1'b0});
    plan.push_back('{OP_READ,   6'd63, 6'd0,  1'b0, 1'b0});
    plan.push_back('{OP_READ,   6'd0,  6'd1,  1'b0, 1'b0});
    plan.push_back('{OP_STEP,   6'd0,  6'd0,  1'b0, 1'b0});
    plan.push_back('{OP_READ,   6'd0,  6'd63, 1'b0, 1'b0});
    plan.push_back('{OP_CLEAR,  6'd1,  6'd0,  1'b1, 1'b0});
    // block sitting on the corner, wrapped in both directions
    plan.push_back('{OP_TOGGLE, 6'd63, 6'd63, 1'b1, 1'b1});
    plan.push_back('{OP_TOGGLE, 6'd0,  6'd63, 1'b1, 1'b1});
    plan.push_back('{OP_TOGGLE, 6'd63, 6'd0,  1'b1, 1'b1});
    plan.push_back('{OP_TOGGLE, 6'd0,  6'd0,  1'b1, 1'b1});
    plan.push_back('{OP_STEP,   6'd63, 6'd0,  1'b0, 1'b0});
    plan.push_back('{OP_READ,   6'd62, 6'd63, 1'b0, 1'b0});
    plan.push_back('{OP_READ,   6'd0,  6'd0,  1'b0, 1'b0});

    repeat (8) @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) drive_item(plan[i].op, plan[i].col, plan[i].row,
                                 plan[i].typed, plan[i].alive);

    // episodes: seed a window, evolve it, probe around it, plus some noise
    while (items_sent < ITEM_TARGET) begin
      quiet = ($urandom_range(0, 4) == 0);
      ox = idx_t'($urandom_range(0, GRID_SIDE - 1));
      oy = idx_t'($urandom_range(0, GRID_SIDE - 1));
      if ($urandom_range(0, 3) == 0)
        drive_item(OP_CLEAR, idx_t'($urandom), idx_t'($urandom), 1'b0, 1'b0);
      n_seed = $urandom_range(4, 24);
      repeat (n_seed)
        drive_item(OP_TOGGLE, ox + idx_t'($urandom_range(0, 7)),
                   oy + idx_t'($urandom_range(0, 7)), 1'b0, 1'b0);
      n_steps = $urandom_range(1, 5);
      repeat (n_steps) begin
        drive_item(OP_STEP, ox + idx_t'($urandom_range(0, 9)) - 1'b1,
                   oy + idx_t'($urandom_range(0, 9)) - 1'b1, 1'b0, 1'b0);
        n_reads = $urandom_range(0, 4);
        repeat (n_reads)
          drive_item(OP_READ, ox + idx_t'($urandom_range(0, 9)) - 1'b1,
                     oy + idx_t'($urandom_range(0, 9)) - 1'b1, 1'b0, 1'b0);
      end
      // noise anywhere on the board
      repeat ($urandom_range(0, 3))
        drive_item(op_t'($urandom_range(0, 3)), idx_t'($urandom), idx_t'($urandom),
                   1'b0, 1'b0);
    end
    item_ch.valid <= 1'b0;
    quiet = 1'b0;

    while (pending_cells.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d beats: %0d toggles, %0d clears, %0d steps, %0d reads",
             items_sent, op_counts[OP_TOGGLE], op_counts[OP_CLEAR],
             op_counts[OP_STEP], op_counts[OP_READ]);
    $display("checked %0d result beats, %0d mismatches", results_checked, errors);
    if (errors == 0) begin
      $display("PASS toroidal_life_grid_stepper");
    end else begin
      $display("FAIL toroidal_life_grid_stepper");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+src
src/tlg_pkg.sv
src/tlg_ifs.sv
src/tlg_ram.sv
src/tlg_row_rule.sv
src/toroidal_life_grid_stepper.sv
tb/toroidal_life_grid_stepper_test.sv
